### hw/rtl/csw_pkg.sv
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types and codes for the counting semaphore with waiter stack.
// ----------------------------------------------------------------------------
package csw_pkg;

  typedef enum logic {
    CMD_WAIT   = 1'b0,
    CMD_SIGNAL = 1'b1
  } csw_cmd_t;

  typedef enum logic [2:0] {
    ST_ACQUIRED = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_WOKE     = 3'd2,
    ST_RAISED   = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_FULL     = 3'd5
  } csw_status_t;

  localparam int unsigned ID_W    = 4;
  localparam int unsigned CNT_W   = 16;

  typedef struct packed {
    csw_cmd_t          cmd;
    logic              task_present;
    logic [ID_W-1:0]   task_id;
  } csw_req_t;

  typedef struct packed {
    csw_status_t       status;
    logic [ID_W-1:0]   woken_task;
    logic [CNT_W-1:0]  count_now;
  } csw_rsp_t;

  typedef logic [CNT_W-1:0] csw_cfg_t;

  // stack requests from the control logic
  typedef struct packed {
    logic              clear;
    logic              push;
    logic              pop;
    logic [ID_W-1:0]   push_id;
  } csw_stack_ctl_t;

  // stack condition seen by the control logic
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [ID_W-1:0]   top;
  } csw_stack_sts_t;

endpackage

### hw/rtl/csw_chan_if.sv
// ----------------------------------------------------------------------------
// csw_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface csw_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/counting_semaphore_waiter_stack.sv
// ----------------------------------------------------------------------------
// counting_semaphore_waiter_stack
// Counting semaphore with a LIFO of blocked task ids.
// ----------------------------------------------------------------------------
// Channels:
//   req : wait/signal requests (cmd, task_present, task_id).
//   rsp : one result per request (status, woken_task, count_now).
//   cfg : write of initial_count; loads the count (saturated to COUNT_BITS)
//         and empties the waiter stack. Always ready; write only when idle.
// Path: a request accepted on req is captured in the input register, decided
// from it and registered into the output register that is shown on rsp.
// Throughput: one request per cycle while rsp is not held. The decision,
// count update and stack push/pop are combinational logic; the stack RAM
// is read one entry ahead so the new top is ready in the cycle after each
// push or pop. Stall: while rsp is held, the input register keeps one
// request and req drops ready; nothing is lost or repeated.
// Reset: count 0, stack empty, both registers empty.
// ----------------------------------------------------------------------------
module counting_semaphore_waiter_stack #(
  parameter int unsigned MAX_WAITERS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  csw_chan_if.sink    req,
  csw_chan_if.source  rsp,
  csw_chan_if.sink    cfg
);
  import csw_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic            in_v;
  csw_req_t        in_d;
  logic            out_v;
  csw_rsp_t        out_d;
  logic            adv;

  logic [COUNT_BITS-1:0] sem_count;
  logic [COUNT_BITS-1:0] sem_count_next;
  logic [COUNT_BITS-1:0] cfg_count;
  csw_status_t           status;
  logic [ID_W-1:0]       woken;
  logic                  push;
  logic                  pop;

  csw_stack_ctl_t  stk_ctl;
  csw_stack_sts_t  stk_sts;

  assign adv       = in_v && (!out_v || rsp.ready);
  assign req.ready = !in_v || adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (req.ready) begin
      in_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_d <= req.data;
    end
  end

  always_comb begin
    sem_count_next = sem_count;
    status         = ST_IGNORED;
    woken          = '0;
    push           = 1'b0;
    pop            = 1'b0;
    unique case (in_d.cmd)
      CMD_WAIT: begin
        priority if (!in_d.task_present) begin
          status = ST_IGNORED;
        end else if (sem_count != '0) begin
          sem_count_next = sem_count - COUNT_BITS'(1);
          status         = ST_ACQUIRED;
        end else if (stk_sts.full) begin
          status = ST_FULL;
        end else begin
          push   = 1'b1;
          status = ST_BLOCKED;
        end
      end
      CMD_SIGNAL: begin
        if (!stk_sts.empty) begin
          pop    = 1'b1;
          woken  = stk_sts.top;
          status = ST_WOKE;
        end else begin
          if (sem_count != COUNT_MAX) begin
            sem_count_next = sem_count + COUNT_BITS'(1);
          end
          status = ST_RAISED;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  // initial count saturates when COUNT_BITS is narrower than the cfg data
  assign cfg_count = (CW'(cfg.data) > CW'(COUNT_MAX)) ? COUNT_MAX
                                                      : COUNT_BITS'(cfg.data);

  assign stk_ctl.clear   = cfg.valid;
  assign stk_ctl.push    = push && adv;
  assign stk_ctl.pop     = pop && adv;
  assign stk_ctl.push_id = in_d.task_id;

  csw_stack #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_stack (
    .clk (clk),
    .rst (rst),
    .ctl (stk_ctl),
    .sts (stk_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sem_count <= '0;
    end else if (cfg.valid) begin
      sem_count <= cfg_count;
    end else if (adv) begin
      sem_count <= sem_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d.status     <= status;
      out_d.woken_task <= woken;
      out_d.count_now  <= CNT_W'(sem_count_next);
    end
  end

  assign rsp.valid = out_v;
  assign rsp.data  = out_d;

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_v && !rsp.ready |=> out_v && $stable(out_d))
    else $error("result changed while stalled");

  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    in_v && out_v && !rsp.ready |-> !req.ready)
    else $error("request taken with no room");

  a_woke_id: assert property (@(posedge clk) disable iff (rst)
    adv && status != ST_WOKE |=> out_d.woken_task == '0)
    else $error("woken id set without a wake");

endmodule

### hw/rtl/csw_ram.sv
// ----------------------------------------------------------------------------
// csw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module csw_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/csw_stack.sv
// ----------------------------------------------------------------------------
// csw_stack
// LIFO of waiter ids: depth counter, RAM and a top-of-stack view that is
// ready in the cycle after any push or pop.
// ----------------------------------------------------------------------------
module csw_stack #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  csw_pkg::csw_stack_ctl_t  ctl,
  output csw_pkg::csw_stack_sts_t  sts
);
  import csw_pkg::*;

  localparam int unsigned DW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

  logic [DW-1:0]   depth;
  logic [DW-1:0]   depth_next;
  logic [DW-1:0]   below_next;
  logic [ID_W-1:0] rd_data;
  logic [ID_W-1:0] byp_id;
  logic            use_byp;

  always_comb begin
    depth_next = depth;
    priority if (ctl.clear) begin
      depth_next = '0;
    end else if (ctl.push) begin
      depth_next = depth + DW'(1);
    end else if (ctl.pop) begin
      depth_next = depth - DW'(1);
    end
  end

  // read ahead at the entry that will be on top next cycle
  assign below_next = depth_next - DW'(1);

  csw_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_WAITERS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push && !ctl.clear),
    .waddr (depth[AW-1:0]),
    .wdata (ctl.push_id),
    .raddr (below_next[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      use_byp <= 1'b0;
    end else begin
      depth   <= depth_next;
      use_byp <= ctl.push && !ctl.clear;
    end
  end

  // RAM reads old data when its address is written, so a fresh push is bypassed
  always_ff @(posedge clk) begin
    byp_id <= ctl.push_id;
  end

  assign sts.empty = (depth == '0);
  assign sts.full  = (depth == DW'(MAX_WAITERS));
  assign sts.top   = use_byp ? byp_id : rd_data;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_WAITERS))
    else $error("waiter depth beyond capacity");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    ctl.push && !ctl.clear |=> sts.top == $past(ctl.push_id))
    else $error("pushed id not on top");

  a_pop_depth: assert property (@(posedge clk) disable iff (rst)
    ctl.pop && !ctl.push && !ctl.clear |=> depth == $past(depth) - DW'(1))
    else $error("pop did not lower depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && sts.full) && !(ctl.pop && sts.empty))
    else $error("push when full or pop when empty");

endmodule
